>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/lfd_pkg.sv
package lfd_pkg;

    localparam int HOLD_DEPTH_DEF = 64;
    localparam int DATA_W         = 8;
    localparam int FIELD_W        = 32;
    localparam int MULT_W         = 16;
    localparam int PROD_W         = FIELD_W + MULT_W;
    localparam int LEN_W          = PROD_W + 1;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int OFF_W          = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADDEND       = 3'd5;

    typedef struct packed {
        logic              start;
        logic [FIELD_W-1:0] field;
        logic [MULT_W-1:0] mult;
        logic [MULT_W-1:0] align;
        logic [MULT_W-1:0] addend;
    } len_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } len_rsp_t;

endpackage

>>> src/length_field_stream_deframer_top.sv
// length field stream deframer
// s_axis carries the raw byte stream, cut anywhere; m_axis returns the same
// bytes in order with tlast on the byte that ends each frame and tuser set on
// a frame whose computed length was zero and was raised to one byte.
// cfg_* writes the six length registers by index, one write per request; it is
// always ready and must only be used while the block is idle.
// a byte of a frame whose length is known passes straight into the output
// register. bytes at a frame start are held in a HOLD_DEPTH byte memory, each
// followed by a check, until the length field is complete; then a check, the
// field read with one memory read per field byte, and one multiply and a
// bit-serial remainder unit give the aligned length, once per frame, and held
// bytes leave one memory read each while the receiver keeps up, with one more
// check at the end.
// the block takes one request at a time; s_axis_tready drops while it works
// and while the output register holds a byte that the receiver stalls.
// reset empties the hold memory and the output register and loads register
// defaults: offset 2, two byte big-endian field, multiplier 1, alignment 1.
module length_field_stream_deframer_top #(
    parameter int HOLD_DEPTH = lfd_pkg::HOLD_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lfd_pkg::DATA_W-1:0]     s_axis_tdata,  // data_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lfd_pkg::DATA_W-1:0]     m_axis_tdata,  // out_byte
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser,  // length_clamped
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lfd_pkg::*;

    localparam int PTR_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int OW    = CNT_W + OFF_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_FRD   = 3'd2;
    localparam logic [2:0] S_FWAIT = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_LWAIT = 3'd5;
    localparam logic [2:0] S_RRD   = 3'd6;
    localparam logic [2:0] S_RWAIT = 3'd7;

    logic [OFF_W-1:0]  off_reg;
    logic [1:0]        size_reg;
    logic              big_reg;
    logic [MULT_W-1:0] mult_reg, align_reg, addend_reg;

    logic [2:0]         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               known_reg, known_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic               clamp_reg, clamp_next;
    logic [2:0]         k_reg, k_next;
    logic [FIELD_W-1:0] fv_reg, fv_next;
    logic               ov_reg, ov_next;
    logic [DATA_W-1:0]  ob_reg, ob_next;
    logic               ol_reg, ol_next;
    logic               oc_reg, oc_next;

    logic [2:0]        sz;
    logic [OW-1:0]     hdr_sum, hdr, off_eff, fidx;
    logic              out_free;
    logic              in_acc;
    logic [LEN_W-1:0]  add_len;
    logic              add_clamp;
    logic [LEN_W-1:0]  cur_rem;
    logic              cur_clamp;
    logic [SUM_W-1:0]  tail_sum, fld_sum;
    logic [PTR_W-1:0]  tail_addr, fld_addr;
    logic              wr_en, rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              len_start;
    len_req_t          lreq;
    len_rsp_t          lrsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= OFF_W'(2);
            size_reg   <= 2'd2;
            big_reg    <= 1'b1;
            mult_reg   <= MULT_W'(1);
            align_reg  <= MULT_W'(1);
            addend_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIELD_OFFSET: off_reg    <= cfg_data[OFF_W-1:0];
                REG_FIELD_SIZE:   size_reg   <= cfg_data[1:0];
                REG_BIG_ENDIAN:   big_reg    <= cfg_data[0];
                REG_MULTIPLIER:   mult_reg   <= cfg_data;
                REG_ALIGNMENT:    align_reg  <= cfg_data;
                REG_ADDEND:       addend_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // field geometry
    assign sz      = (size_reg == 2'd3) ? 3'd4 : {1'b0, size_reg};
    assign hdr_sum = OW'(off_reg) + OW'(sz);
    assign hdr     = (hdr_sum > OW'(HOLD_DEPTH)) ? OW'(HOLD_DEPTH) : hdr_sum;
    assign off_eff = (hdr_sum > OW'(HOLD_DEPTH)) ? OW'(HOLD_DEPTH) - OW'(sz) : OW'(off_reg);
    assign fidx    = big_reg ? off_eff + OW'(k_reg) : off_eff + OW'(sz) - OW'(1) - OW'(k_reg);

    // circular addressing
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign tail_addr = (tail_sum >= SUM_W'(HOLD_DEPTH)) ?
                       PTR_W'(tail_sum - SUM_W'(HOLD_DEPTH)) : PTR_W'(tail_sum);
    assign fld_sum   = SUM_W'(head_reg) + SUM_W'(fidx[CNT_W-1:0]);
    assign fld_addr  = (fld_sum >= SUM_W'(HOLD_DEPTH)) ?
                       PTR_W'(fld_sum - SUM_W'(HOLD_DEPTH)) : PTR_W'(fld_sum);

    assign add_len   = (addend_reg == '0) ? LEN_W'(1) : LEN_W'(addend_reg);
    assign add_clamp = (addend_reg == '0);
    assign cur_rem   = known_reg ? rem_reg : add_len;
    assign cur_clamp = known_reg ? clamp_reg : add_clamp;

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign lreq.start  = len_start;
    assign lreq.field  = fv_reg;
    assign lreq.mult   = mult_reg;
    assign lreq.align  = align_reg;
    assign lreq.addend = addend_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        known_next = known_reg;
        rem_next   = rem_reg;
        clamp_next = clamp_reg;
        k_next     = k_reg;
        fv_next    = fv_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        oc_next    = oc_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        len_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cnt_reg == '0 && (known_reg || sz == 3'd0))
                    begin
                        ov_next = 1'b1;
                        ob_next = s_axis_tdata;
                        ol_next = (cur_rem == LEN_W'(1));
                        oc_next = cur_clamp;
                        rem_next = cur_rem - LEN_W'(1);
                        known_next = (cur_rem != LEN_W'(1));
                        clamp_next = (cur_rem != LEN_W'(1)) && cur_clamp;
                    end
                    else
                    begin
                        if (cnt_reg < CNT_W'(HOLD_DEPTH))
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                priority if (known_reg)
                begin
                    state_next = (cnt_reg == '0) ? S_IDLE : S_RRD;
                end
                else if (sz == 3'd0)
                begin
                    known_next = 1'b1;
                    rem_next   = add_len;
                    clamp_next = add_clamp;
                    state_next = (cnt_reg == '0) ? S_IDLE : S_RRD;
                end
                else if (OW'(cnt_reg) >= hdr)
                begin
                    k_next     = '0;
                    fv_next    = '0;
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = fld_addr;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                fv_next = {fv_reg[FIELD_W-DATA_W-1:0], rd_data};
                k_next  = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == sz) ? S_LEN : S_FRD;
            end
            S_LEN:
            begin
                len_start  = 1'b1;
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (lrsp.done)
                begin
                    known_next = 1'b1;
                    rem_next   = (lrsp.len == '0) ? LEN_W'(1) : lrsp.len;
                    clamp_next = (lrsp.len == '0);
                    state_next = S_RRD;
                end
            end
            S_RRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = rd_data;
                    ol_next    = (rem_reg == LEN_W'(1));
                    oc_next    = clamp_reg;
                    rem_next   = rem_reg - LEN_W'(1);
                    known_next = (rem_reg != LEN_W'(1));
                    clamp_next = (rem_reg != LEN_W'(1)) && clamp_reg;
                    head_next  = (head_reg == PTR_W'(HOLD_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ((rem_reg != LEN_W'(1)) && cnt_reg != CNT_W'(1)) ?
                                 S_RRD : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            known_reg <= 1'b0;
            rem_reg   <= '0;
            clamp_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            known_reg <= known_next;
            rem_reg   <= rem_next;
            clamp_reg <= clamp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg  <= k_next;
        fv_reg <= fv_next;
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        oc_reg <= oc_next;
    end

    lfd_hold_mem #(
        .DEPTH (HOLD_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfd_len_unit u_len (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = ob_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = oc_reg;

endmodule

>>> src/lfd_hold_mem.sv
module lfd_hold_mem #(
    parameter int DEPTH = lfd_pkg::HOLD_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [lfd_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [lfd_pkg::DATA_W-1:0] rd_data
);
    import lfd_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/lfd_len_unit.sv
module lfd_len_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  lfd_pkg::len_req_t req,
    output lfd_pkg::len_rsp_t rsp
);
    import lfd_pkg::*;

    localparam logic [1:0] LU_IDLE = 2'd0;
    localparam logic [1:0] LU_DIV  = 2'd1;
    localparam logic [1:0] LU_FIN  = 2'd2;
    localparam int         CNT_W   = $clog2(PROD_W);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] div_reg, div_next;
    logic [MULT_W-1:0] rem_reg, rem_next;
    logic [MULT_W-1:0] al_reg, al_next;
    logic [MULT_W-1:0] add_reg, add_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] product;
    logic [MULT_W:0]   trial;
    logic [MULT_W-1:0] pad;

    assign product = PROD_W'(req.field) * PROD_W'(req.mult);
    assign trial   = {rem_reg, div_reg[PROD_W-1]};
    assign pad     = (rem_reg == '0) ? '0 : al_reg - rem_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        al_next    = al_reg;
        add_next   = add_reg;
        len_next   = len_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            LU_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = product;
                    div_next   = product;
                    rem_next   = '0;
                    cnt_next   = '0;
                    al_next    = (req.align == '0) ? MULT_W'(1) : req.align;
                    add_next   = req.addend;
                    phase_next = LU_DIV;
                end
            end
            LU_DIV:
            begin
                rem_next = (trial >= {1'b0, al_reg}) ? MULT_W'(trial - {1'b0, al_reg})
                                                     : MULT_W'(trial);
                div_next = {div_reg[PROD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    phase_next = LU_FIN;
                end
            end
            LU_FIN:
            begin
                len_next   = LEN_W'(prod_reg) + LEN_W'(pad) + LEN_W'(add_reg);
                done_next  = 1'b1;
                phase_next = LU_IDLE;
            end
            default:
            begin
                phase_next = LU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        al_reg   <= al_next;
        add_reg  <= add_next;
        len_reg  <= len_next;
    end

    assign rsp.done = done_reg;
    assign rsp.len  = len_reg;

endmodule

>>> src/lfd_checker.sv
`include "assert_macros.svh"

module lfd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lfd_pkg::DATA_W-1:0]     m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tuser
);
    import lfd_pkg::*;

    logic              out_stall;
    logic              in_acc;
    logic [DATA_W+1:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_word  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

    // a stalled output byte holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_stall |=> (m_axis_tvalid && $stable(out_word)))

    // a clamped frame is a single byte, so it always ends there
    `ASSERT_NEVER(a_clamp_last, clk, rst_n, m_axis_tvalid && m_axis_tuser && !m_axis_tlast)

    // no new request while a stalled byte waits
    `ASSERT_NEVER(a_ready_stall, clk, rst_n, s_axis_tready && out_stall)

    // an accepted request fills the output register or occupies the sequencer
    `ASSERT_CLK(a_accept_busy, clk, rst_n, in_acc |=> (!s_axis_tready || m_axis_tvalid))

endmodule

bind length_field_stream_deframer_top lfd_checker u_lfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

>>> bench/length_field_stream_deframer_top_test.sv
`timescale 1ns / 100ps

module length_field_stream_deframer_top_test;
    import lfd_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       clamped;
    } out_byte_t;

    class deframe_scoreboard;
        logic [5:0]      offset;
        logic [1:0]      size_code;
        logic            msb_first;
        logic [15:0]     mult;
        logic [15:0]     align;
        logic [15:0]     addend;
        logic [7:0]      held[DEPTH];
        int unsigned     held_count;
        bit              len_known;
        longint unsigned remaining;
        bit              clamp_flag;
        out_byte_t       released[$];
        int              errors;

        function new();
            offset = 2;
            size_code = 2;
            msb_first = 1;
            mult = 1;
            align = 1;
            addend = 0;
            held_count = 0;
            len_known = 0;
            remaining = 0;
            clamp_flag = 0;
            errors = 0;
        endfunction

        function int field_len();
            case (size_code)
                2'd0: return 0;
                2'd1: return 1;
                2'd2: return 2;
                default: return 4;
            endcase
        endfunction

        function int header_len();
            int h;
            h = offset + field_len();
            return (h > DEPTH) ? DEPTH : h;
        endfunction

        function int field_pos();
            int p;
            p = offset;
            if (p + field_len() > DEPTH)
                p = DEPTH - field_len();
            return p;
        endfunction

        function longint unsigned frame_len(longint unsigned v);
            longint unsigned al;
            longint unsigned s;
            if (field_len() == 0)
                return addend;
            al = (align == 0) ? 1 : align;
            s = longint'(mult) * v;
            s = (s + al - 1) / al * al;
            return s + addend;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_FIELD_OFFSET: offset = val[5:0];
                REG_FIELD_SIZE:   size_code = val[1:0];
                REG_BIG_ENDIAN:   msb_first = val[0];
                REG_MULTIPLIER:   mult = val;
                REG_ALIGNMENT:    align = val;
                REG_ADDEND:       addend = val;
                default: ;
            endcase
        endfunction

        function void resolve_length();
            longint unsigned v;
            longint unsigned l;
            int fl;
            int p;
            fl = field_len();
            if (len_known)
                return;
            if (fl != 0 && held_count < header_len())
                return;
            v = 0;
            p = field_pos();
            for (int i = 0; i < fl; i++)
                v = (v << 8) | held[msb_first ? (p + i) : (p + fl - 1 - i)];
            l = frame_len(v);
            clamp_flag = (l == 0);
            remaining = (l == 0) ? 1 : l;
            len_known = 1;
        endfunction

        function void release_byte(logic [7:0] b);
            out_byte_t o;
            o.data = b;
            o.last = (remaining == 1);
            o.clamped = clamp_flag;
            released.push_back(o);
            remaining--;
            if (remaining == 0)
            begin
                len_known = 0;
                clamp_flag = 0;
            end
        endfunction

        function void note_request(logic [7:0] b);
            int i;
            if (held_count == 0)
                resolve_length();
            if (len_known && held_count == 0)
            begin
                release_byte(b);
                return;
            end
            if (held_count < DEPTH)
            begin
                held[held_count] = b;
                held_count++;
            end
            forever
            begin
                resolve_length();
                if (!len_known || held_count == 0)
                    break;
                i = 0;
                while (len_known && i < held_count)
                begin
                    release_byte(held[i]);
                    i++;
                end
                for (int k = 0; k + i < held_count; k++)
                    held[k] = held[k + i];
                held_count -= i;
            end
        endfunction

        function void check_result(logic [7:0] b, logic last, logic clamped);
            out_byte_t e;
            if (released.size() == 0)
            begin
                $error("unexpected output byte %0h", b);
                errors++;
                return;
            end
            e = released.pop_front();
            if (b !== e.data)
            begin
                $error("out_byte expected %0h actual %0h", e.data, b);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("frame_last expected %0b actual %0b", e.last, last);
                errors++;
            end
            if (clamped !== e.clamped)
            begin
                $error("length_clamped expected %0b actual %0b", e.clamped, clamped);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    deframe_scoreboard sb;
    int  bytes_sent;
    int  burst_left;
    bit  no_gaps;
    bit  long_hold;
    int  quiet_cycles;

    length_field_stream_deframer_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int cyc;
        mode = 0;
        cyc = 0;
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (long_hold)
            begin
                m_axis_tready <= 0;
                repeat (300) @(negedge clk);
                long_hold = 0;
            end
            else
            begin
                case (mode)
                    0: m_axis_tready <= 1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 2);
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.released.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(int off, int sz, int be, int mul, int al, int add);
        logic [15:0] vals[6];
        vals = '{16'(off), 16'(sz), 16'(be), 16'(mul), 16'(al), 16'(add)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        cfg_valid <= 0;
    endtask

    // one-byte frames drain whatever is still held
    task automatic flush_held();
        wait_drained();
        configure(0, 0, 0, 0, 1, 0);
        send_byte(8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    task automatic send_frame(longint unsigned v, bit truncate);
        logic [7:0] fr[$];
        longint unsigned total;
        int fl;
        int p;
        int hdr;
        fl = sb.field_len();
        p = sb.field_pos();
        hdr = sb.header_len();
        total = sb.frame_len(v);
        if (total == 0)
            total = 1;
        if (total < hdr)
            total = hdr;
        for (int i = 0; i < total; i++)
            fr.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < fl; i++)
            fr[p + i] = sb.msb_first ? 8'(v >> (8 * (fl - 1 - i))) : 8'(v >> (8 * i));
        if (truncate && hdr > 1)
            total = $urandom_range(1, hdr - 1);
        for (int i = 0; i < total; i++)
            send_byte(fr[i]);
    endtask

    initial
    begin
        int phase;
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        bytes_sent = 0;
        burst_left = 0;
        no_gaps = 0;
        long_hold = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset settings: two byte big-endian field at offset 2
        send_frame(0, 0);
        send_frame(6, 0);
        send_frame(1, 0);
        wait_drained();

        // no field and no addend: every byte is its own clamped frame
        configure(0, 0, 0, 0, 1, 0);
        for (int i = 0; i < 4; i++)
            send_byte(i[0] ? 8'hff : 8'h00);
        wait_drained();

        // field ends exactly at the end of the hold memory, zero length
        configure(60, 3, 0, 65535, 65535, 0);
        send_frame(0, 0);
        flush_held();

        // field running past the hold memory saturates; frame ends inside held bytes
        configure(63, 2, 1, 1, 1, 0);
        send_frame(3, 0);
        flush_held();

        // random frames; every fourth phase from phase 1 has no input gaps, phase 2 a long receiver hold-off
        phase = 0;
        while (bytes_sent < 470)
        begin
            no_gaps = (phase % 4 == 1);
            configure($urandom_range(0, 8), $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 6));
            if (phase == 2)
                long_hold = 1;
            for (int f = 0; f < 6; f++)
                send_frame($urandom_range(0, 10), $urandom_range(0, 9) == 0);
            flush_held();
            phase++;
        end
        no_gaps = 0;

        // largest addend: a frame far too long to finish
        configure(0, 0, 1, 1, 1, 65535);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom_range(0, 255)));
        wait_drained();

        if (sb.errors == 0 && sb.released.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
